// ===== hdl/rmsd_pkg.sv =====
// rmsd_pkg: widths, constants and the result record for the running mean /
// stdev stop-test block. No dependencies; imported by every module of the block.

package rmsd_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int COUNT_WIDTH = 32;

	localparam int SAMPLE_W    = 48;
	localparam int STDEV_W     = 47;
	localparam int VAR_W       = 64;
	localparam int COUNT_OUT_W = 32;
	localparam int REL_W       = 16;
	localparam int MINS_W      = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	// shared adder width and shift register width
	localparam int UW      = VAR_W;
	localparam int ROOT_W  = (VAR_W + FRAC_BITS + 1) / 2;
	localparam int SW      = 2 * ROOT_W;
	localparam int DIFF_W  = SAMPLE_W + 1;
	localparam int NP1_W   = COUNT_WIDTH + 1;
	localparam int IT_W    = $clog2(SW + 1);

	// 3.92 with 16 fraction bits
	localparam int K_W = 18;
	localparam logic [K_W-1:0] K392 = 18'd256901;

	localparam logic [CFG_IDX_W-1:0] CFG_REL_ERROR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 2'd1;

	localparam logic [REL_W-1:0]  REL_RESET  = 16'd655;
	localparam logic [MINS_W-1:0] MINS_RESET = 32'd256;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mean;
		logic [STDEV_W-1:0]         stdev;
		logic [COUNT_OUT_W-1:0]     count;
		logic                       done;
	} res_t;

endpackage

// ===== hdl/rmsd_addsub.sv =====
// rmsd_addsub: the one shared adder/subtractor used for every divide, multiply,
// root and compare step. Depends on rmsd_pkg.

module rmsd_addsub (
	input  logic [rmsd_pkg::UW-1:0] x,
	input  logic [rmsd_pkg::UW-1:0] y,
	input  logic                    sub,
	output logic [rmsd_pkg::UW-1:0] res,
	output logic                    co
);
	import rmsd_pkg::*;

	logic [UW:0] sum;

	assign sum = {1'b0, x} + {1'b0, (sub ? ~y : y)} + (UW+1)'(sub);
	assign res = sum[UW-1:0];
	// carry on add, borrow (x < y) on subtract
	assign co  = sub ? ~sum[UW] : sum[UW];

endmodule

// ===== hdl/rmsd_seq.sv =====
// rmsd_seq: sequencer and working registers; runs divide, multiply and root
// bit by bit through rmsd_addsub. Depends on rmsd_pkg and rmsd_addsub.

module rmsd_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [rmsd_pkg::SAMPLE_W-1:0] sample,
	input  logic [rmsd_pkg::REL_W-1:0]        rel_error,
	input  logic [rmsd_pkg::MINS_W-1:0]       min_samples,
	input  logic                              take,
	output logic                              idle,
	output logic                              res_valid,
	output rmsd_pkg::res_t                    res
);
	import rmsd_pkg::*;

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] ST_IDLE  = 5'd0;
	localparam logic [ST_W-1:0] ST_FIRST = 5'd1;
	localparam logic [ST_W-1:0] ST_DIFF  = 5'd2;
	localparam logic [ST_W-1:0] ST_DIVD  = 5'd3;
	localparam logic [ST_W-1:0] ST_MEAN  = 5'd4;
	localparam logic [ST_W-1:0] ST_MUL1  = 5'd5;
	localparam logic [ST_W-1:0] ST_LD2   = 5'd6;
	localparam logic [ST_W-1:0] ST_MUL2  = 5'd7;
	localparam logic [ST_W-1:0] ST_LDV   = 5'd8;
	localparam logic [ST_W-1:0] ST_DIVV  = 5'd9;
	localparam logic [ST_W-1:0] ST_T1    = 5'd10;
	localparam logic [ST_W-1:0] ST_VADD  = 5'd11;
	localparam logic [ST_W-1:0] ST_DIVQ  = 5'd12;
	localparam logic [ST_W-1:0] ST_SQRT  = 5'd13;
	localparam logic [ST_W-1:0] ST_STD   = 5'd14;
	localparam logic [ST_W-1:0] ST_CNT   = 5'd15;
	localparam logic [ST_W-1:0] ST_MULK  = 5'd16;
	localparam logic [ST_W-1:0] ST_LDR   = 5'd17;
	localparam logic [ST_W-1:0] ST_MULR  = 5'd18;
	localparam logic [ST_W-1:0] ST_CMP   = 5'd19;
	localparam logic [ST_W-1:0] ST_OUT   = 5'd20;

	// product offsets inside {a_q, s_q}
	localparam int P2_LO = SW - SAMPLE_W + FRAC_BITS;
	localparam int P2_HI = P2_LO + VAR_W;

	logic [ST_W-1:0]            st_q;
	logic [IT_W-1:0]            it_q;
	logic signed [SAMPLE_W-1:0] mean_q;
	logic [VAR_W-1:0]           var_q;
	logic [STDEV_W-1:0]         stdev_q;
	logic [COUNT_WIDTH-1:0]     cnt_q;

	logic [UW-1:0]              a_q;
	logic [UW-1:0]              b_q;
	logic [SW-1:0]              s_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic                       neg_q;
	logic [SAMPLE_W-1:0]        adm_q;
	logic [VAR_W-1:0]           tmp_q;
	logic                       ovf_q;
	logic                       done_q;

	logic [UW-1:0]              ux;
	logic [UW-1:0]              uy;
	logic                       usub;
	logic [UW-1:0]              ures;
	logic                       uco;

	logic                       last;
	logic [NP1_W-1:0]           np1;
	logic [DIFF_W-1:0]          diff_w;
	logic [DIFF_W-1:0]          absd;
	logic [SAMPLE_W-1:0]        absmean;
	logic [UW+SW-1:0]           prod_w;
	logic [DIFF_W-1:0]          p1;
	logic [VAR_W-1:0]           t2sat;
	logic [VAR_W:0]             lhs;
	logic [VAR_W-1:0]           rhs;
	logic [VAR_W-1:0]           vsat;
	logic [UW-1:0]              x_ext;
	logic [UW-1:0]              mean_ext;

	rmsd_addsub u_alu (
		.x   (ux),
		.y   (uy),
		.sub (usub),
		.res (ures),
		.co  (uco)
	);

	assign last     = (it_q == '0);
	assign np1      = {1'b0, cnt_q} + NP1_W'(1);
	assign x_ext    = {{(UW-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
	assign mean_ext = {{(UW-SAMPLE_W){mean_q[SAMPLE_W-1]}}, mean_q};
	assign diff_w   = ures[DIFF_W-1:0];
	assign absd     = diff_w[DIFF_W-1] ? (~diff_w + DIFF_W'(1)) : diff_w;
	assign absmean  = mean_q[SAMPLE_W-1] ? (~$unsigned(mean_q) + SAMPLE_W'(1))
		: $unsigned(mean_q);

	// low product bits land at the top of s_q, high bits in a_q
	assign prod_w = {a_q, s_q};
	assign p1     = prod_w[SW-NP1_W +: DIFF_W];
	assign t2sat  = (|prod_w[UW+SW-1:P2_HI]) ? {VAR_W{1'b1}} : prod_w[P2_LO +: VAR_W];
	assign lhs    = prod_w[SW-K_W +: VAR_W+1];
	assign rhs    = prod_w[SW-REL_W +: VAR_W];
	assign vsat   = uco ? {VAR_W{1'b1}} : ures;

	always_comb begin
		ux   = '0;
		uy   = '0;
		usub = 1'b0;
		unique case (st_q)
			ST_DIFF: begin
				ux   = x_ext;
				uy   = mean_ext;
				usub = 1'b1;
			end
			ST_DIVD, ST_DIVV, ST_DIVQ: begin
				ux   = {a_q[UW-2:0], s_q[SW-1]};
				uy   = b_q;
				usub = 1'b1;
			end
			ST_MEAN: begin
				ux   = mean_ext;
				uy   = UW'(s_q[SAMPLE_W-1:0]);
				usub = neg_q;
			end
			ST_MUL1, ST_MUL2, ST_MULK, ST_MULR: begin
				ux = a_q;
				uy = s_q[0] ? b_q : '0;
			end
			ST_T1: begin
				ux   = var_q;
				uy   = s_q[VAR_W-1:0];
				usub = 1'b1;
			end
			ST_VADD: begin
				ux = var_q;
				uy = tmp_q;
			end
			ST_SQRT: begin
				ux   = {a_q[UW-3:0], s_q[SW-1:SW-2]};
				uy   = {b_q[UW-3:0], 2'b01};
				usub = 1'b1;
			end
			ST_CMP: begin
				ux   = rhs;
				uy   = tmp_q;
				usub = 1'b1;
			end
			default: ;
		endcase
	end

	// control and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			it_q    <= '0;
			mean_q  <= '0;
			var_q   <= '0;
			stdev_q <= '1;
			cnt_q   <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (start) st_q <= (cnt_q == '0) ? ST_FIRST : ST_DIFF;
				end
				ST_FIRST: begin
					mean_q <= x_q;
					st_q   <= ST_CNT;
				end
				ST_DIFF: begin
					it_q <= IT_W'(DIFF_W - 1);
					st_q <= ST_DIVD;
				end
				ST_DIVD: begin
					if (last) st_q <= ST_MEAN;
					else it_q <= it_q - IT_W'(1);
				end
				ST_MEAN: begin
					mean_q <= ures[SAMPLE_W-1:0];
					it_q   <= IT_W'(NP1_W - 1);
					st_q   <= ST_MUL1;
				end
				ST_MUL1: begin
					if (last) st_q <= ST_LD2;
					else it_q <= it_q - IT_W'(1);
				end
				ST_LD2: begin
					it_q <= IT_W'(SAMPLE_W - 1);
					st_q <= ST_MUL2;
				end
				ST_MUL2: begin
					if (last) st_q <= ST_LDV;
					else it_q <= it_q - IT_W'(1);
				end
				ST_LDV: begin
					it_q <= IT_W'(VAR_W - 1);
					st_q <= ST_DIVV;
				end
				ST_DIVV: begin
					if (last) st_q <= ST_T1;
					else it_q <= it_q - IT_W'(1);
				end
				ST_T1: begin
					var_q <= ures;
					st_q  <= ST_VADD;
				end
				ST_VADD: begin
					var_q <= vsat;
					it_q  <= IT_W'(SW - 1);
					st_q  <= ST_DIVQ;
				end
				ST_DIVQ: begin
					if (last) begin
						it_q <= IT_W'(ROOT_W - 1);
						st_q <= ST_SQRT;
					end else begin
						it_q <= it_q - IT_W'(1);
					end
				end
				ST_SQRT: begin
					if (last) st_q <= ST_STD;
					else it_q <= it_q - IT_W'(1);
				end
				ST_STD: begin
					stdev_q <= b_q[STDEV_W-1:0];
					st_q    <= ST_CNT;
				end
				ST_CNT: begin
					if (cnt_q != '1) cnt_q <= cnt_q + COUNT_WIDTH'(1);
					it_q <= IT_W'(K_W - 1);
					st_q <= ST_MULK;
				end
				ST_MULK: begin
					if (last) st_q <= ST_LDR;
					else it_q <= it_q - IT_W'(1);
				end
				ST_LDR: begin
					it_q <= IT_W'(REL_W - 1);
					st_q <= ST_MULR;
				end
				ST_MULR: begin
					if (last) st_q <= ST_CMP;
					else it_q <= it_q - IT_W'(1);
				end
				ST_CMP: st_q <= ST_OUT;
				ST_OUT: begin
					if (take) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (start) x_q <= sample;
			end
			ST_DIFF: begin
				neg_q <= diff_w[DIFF_W-1];
				a_q   <= '0;
				b_q   <= UW'(np1);
				s_q   <= {absd, {(SW-DIFF_W){1'b0}}};
			end
			ST_DIVD, ST_DIVV, ST_DIVQ: begin
				s_q <= {s_q[SW-2:0], ~uco};
				if (st_q == ST_DIVQ && last) begin
					// quotient stays in s_q as the radicand
					a_q <= '0;
					b_q <= '0;
				end else if (!uco) begin
					a_q <= ures;
				end else begin
					a_q <= ux;
				end
			end
			ST_MEAN: begin
				adm_q <= s_q[SAMPLE_W-1:0];
				a_q   <= '0;
				b_q   <= UW'(s_q[SAMPLE_W-1:0]);
				s_q   <= SW'(np1);
			end
			ST_MUL1, ST_MUL2, ST_MULK, ST_MULR: begin
				a_q <= {uco, ures[UW-1:1]};
				s_q <= {ures[0], s_q[SW-1:1]};
			end
			ST_LD2: begin
				a_q <= '0;
				b_q <= UW'(p1);
				s_q <= SW'(adm_q);
			end
			ST_LDV: begin
				tmp_q <= t2sat;
				a_q   <= '0;
				b_q   <= UW'(cnt_q);
				s_q   <= {var_q, {(SW-VAR_W){1'b0}}};
			end
			ST_VADD: begin
				a_q <= '0;
				b_q <= UW'(cnt_q);
				s_q <= SW'({vsat, {FRAC_BITS{1'b0}}});
			end
			ST_SQRT: begin
				s_q <= {s_q[SW-3:0], 2'b00};
				if (!uco) begin
					a_q <= ures;
					b_q <= {b_q[UW-2:0], 1'b1};
				end else begin
					a_q <= ux;
					b_q <= {b_q[UW-2:0], 1'b0};
				end
			end
			ST_CNT: begin
				a_q <= '0;
				b_q <= UW'(stdev_q);
				s_q <= SW'(K392);
			end
			ST_LDR: begin
				tmp_q <= lhs[VAR_W-1:0];
				ovf_q <= lhs[VAR_W];
				a_q   <= '0;
				b_q   <= UW'(absmean);
				s_q   <= SW'(rel_error);
			end
			ST_CMP: begin
				done_q <= !(ovf_q || uco) && (MINS_W'(cnt_q) >= min_samples);
			end
			default: ;
		endcase
	end

	assign idle      = (st_q == ST_IDLE);
	assign res_valid = (st_q == ST_OUT);
	assign res.mean  = mean_q;
	assign res.stdev = stdev_q;
	assign res.count = COUNT_OUT_W'(cnt_q);
	assign res.done  = done_q;

endmodule

// ===== hdl/running_mean_stdev_stop_test_top.sv =====
// Top level of the running mean / stdev stop test: config registers, output
// register and the sequencer. Depends on rmsd_pkg, rmsd_seq, rmsd_addsub.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | sample
//   out     | out_valid / out_ready| mean_out, stdev_out, count_out, done_res
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Every bit of the three divides, two multiplies, the 40-step root and the
// stop-test products goes through one 64-bit adder, one bit per cycle.
// in_ready is high only while the sequencer is idle; a result held in the output
// register does not stop the next sample being taken.
// Reset sets count, mean and variance to zero and stdev to all ones.

module running_mean_stdev_stop_test_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [rmsd_pkg::SAMPLE_W-1:0]  sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [rmsd_pkg::SAMPLE_W-1:0]  mean_out,
	output logic [rmsd_pkg::STDEV_W-1:0]          stdev_out,
	output logic [rmsd_pkg::COUNT_OUT_W-1:0]      count_out,
	output logic                                  done_res,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rmsd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rmsd_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import rmsd_pkg::*;

	logic [REL_W-1:0]  rel_q;
	logic [MINS_W-1:0] mins_q;
	logic              ovalid_q;
	res_t              res_q;

	logic              idle;
	logic              res_valid;
	res_t              res;
	logic              take;

	assign cfg_ready = 1'b1;
	assign in_ready  = idle;
	assign take      = res_valid && (!ovalid_q || out_ready);

	rmsd_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_valid && in_ready),
		.sample      (sample),
		.rel_error   (rel_q),
		.min_samples (mins_q),
		.take        (take),
		.idle        (idle),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q  <= REL_RESET;
			mins_q <= MINS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_REL_ERROR:   rel_q  <= cfg_data[REL_W-1:0];
				CFG_MIN_SAMPLES: mins_q <= cfg_data[MINS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (take) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= res;
	end

	assign out_valid = ovalid_q;
	assign mean_out  = res_q.mean;
	assign stdev_out = res_q.stdev;
	assign count_out = res_q.count;
	assign done_res  = res_q.done;

endmodule

// ===== hdl/rmsd_checker.sv =====
// rmsd_checker: port-level assertions for the stop-test top level, and the bind
// that attaches them. Depends on rmsd_pkg and running_mean_stdev_stop_test_top.

module rmsd_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [rmsd_pkg::SAMPLE_W-1:0]  mean_out,
	input logic [rmsd_pkg::STDEV_W-1:0]          stdev_out,
	input logic [rmsd_pkg::COUNT_OUT_W-1:0]      count_out,
	input logic                                  done_res
);
	import rmsd_pkg::*;

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_out) && $stable(stdev_out)
			&& $stable(count_out) && $stable(done_res))
		else $error("result changed while stalled");

	// one item in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after accepting an item");

	// after the first item stdev is still undefined
	a_first_stdev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && count_out == COUNT_OUT_W'(1) |-> stdev_out == {STDEV_W{1'b1}})
		else $error("stdev defined after a single item");

	// undefined stdev can never pass the test
	a_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stdev_out == {STDEV_W{1'b1}} |-> !done_res)
		else $error("done raised with undefined stdev");

endmodule

bind running_mean_stdev_stop_test_top rmsd_checker u_rmsd_checker (.*);
